@@ hdl/quaternion_arithmetic_unit_defines.svh @@
// Assertion macros used by the quaternion unit top level.
`ifndef QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH
`define QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define QAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qau assertion failed");
// Next-cycle implication.
`define QAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("qau assertion failed");
`else
`define QAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define QAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/qau_pkg.sv @@
// Package: widths, command codes, pipeline records and helpers of the quaternion unit.
`timescale 1ns / 1ps
package qau_pkg;

	localparam int CW       = 16;                 // component width
	localparam int FB       = 12;                 // fraction bits
	localparam int SW       = 2 * CW + 1;         // sum of squares
	localparam int NW       = CW + 1;             // norm
	localparam int PW       = 2 * CW + 2;         // product sums
	localparam int QB       = CW + 2;             // doubled quotient plus overflow bit
	localparam int DW_A     = SW + CW + 1;
	localparam int DW_B     = CW + 2 * FB + 1;
	localparam int DW       = (DW_A > DW_B) ? DW_A : DW_B;
	localparam int SQ_CELLS = CW + 1;             // one root bit per cell
	localparam int DV_CELLS = QB;                 // one quotient bit per cell

	localparam logic [2:0] CMD_ADD  = 3'd0;
	localparam logic [2:0] CMD_SUB  = 3'd1;
	localparam logic [2:0] CMD_MUL  = 3'd2;
	localparam logic [2:0] CMD_CONJ = 3'd3;
	localparam logic [2:0] CMD_INV  = 3'd4;
	localparam logic [2:0] CMD_NRMZ = 3'd5;
	localparam logic [2:0] CMD_NORM = 3'd6;

	typedef logic signed [CW-1:0] comp_t;

	localparam comp_t CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam comp_t CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [PW-1:0] RND_HALF = PW'(1) << (FB - 1);
	localparam logic [NW-1:0] NORM_MAX = NW'(1) << CW;

	typedef struct packed {
		comp_t val;
		logic  sat;
	} clip_t;

	// square-root chain record
	typedef struct packed {
		logic [2:0]          cmd;
		logic [3:0][CW-1:0]  r;
		logic                sat;
		logic [3:0][CW-1:0]  mag;
		logic [3:0]          neg;
		logic [SW-1:0]       s;
		logic [SW-1:0]       rem;
		logic [SW:0]         res;
		logic [SW-1:0]       sbit;
	} sq_t;

	// divider chain record
	typedef struct packed {
		logic [2:0]          cmd;
		logic [3:0][CW-1:0]  r;
		logic                sat;
		logic                dz;
		logic [NW-1:0]       norm;
		logic [DW-1:0]       dsh;
		logic [3:0][DW-1:0]  rem;
		logic [3:0][QB-1:0]  q;
		logic [3:0]          neg;
	} dv_t;

	function automatic clip_t clip_comp(input logic signed [PW-1:0] v);
		clip_t c;
		if (v > PW'(CMAX)) begin
			c.val = CMAX;
			c.sat = 1'b1;
		end else if (v < PW'(CMIN)) begin
			c.val = CMIN;
			c.sat = 1'b1;
		end else begin
			c.val = v[CW-1:0];
			c.sat = 1'b0;
		end
		return c;
	endfunction

endpackage

@@ hdl/qau_if.sv @@
// Request and result channel interfaces of the quaternion unit.
`timescale 1ns / 1ps
interface qau_op_if;
	import qau_pkg::*;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	comp_t       a_w, a_x, a_y, a_z;
	comp_t       b_w, b_x, b_y, b_z;
	modport source(output valid, command, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
		input ready);
	modport sink(input valid, command, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
		output ready);
endinterface

interface qau_res_if;
	import qau_pkg::*;
	logic           valid;
	logic           ready;
	comp_t          r_w, r_x, r_y, r_z;
	logic [NW-1:0]  norm_value;
	logic           divide_by_zero;
	logic           saturated;
	modport source(output valid, r_w, r_x, r_y, r_z, norm_value, divide_by_zero,
		saturated, input ready);
	modport sink(input valid, r_w, r_x, r_y, r_z, norm_value, divide_by_zero,
		saturated, output ready);
endinterface

@@ hdl/qau_front.sv @@
// Front end: products, squares and the simple operations, two pipeline stages.
`timescale 1ns / 1ps
module qau_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    in_cmd,
	input  logic [3:0][qau_pkg::CW-1:0]   in_a,
	input  logic [3:0][qau_pkg::CW-1:0]   in_b,
	output logic                          out_valid,
	input  logic                          out_ready,
	output qau_pkg::sq_t                  out_data
);
	import qau_pkg::*;

	logic                  v_s1, v_s2, en1, en2;
	logic signed [2*CW-1:0] p_s1 [4][4];
	logic [2*CW-1:0]       sq_s1 [4];
	logic [2:0]            cmd_s1;
	logic [3:0][CW-1:0]    r_s1, mag_s1;
	logic [3:0]            neg_s1;
	logic                  sat_s1;
	sq_t                   d_s2;

	logic [3:0][CW-1:0]    r_c, mag_c;
	logic [3:0]            neg_c, sat_c;
	sq_t                   nx2;

	assign en2 = !v_s2 || out_ready;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;
	assign out_valid = v_s2;
	assign out_data = d_s2;

	// simple ops and divider numerators
	always_comb begin
		logic signed [PW-1:0] av, bv, cv, mv;
		clip_t                c;
		for (int i = 0; i < 4; i++) begin
			av = PW'($signed(in_a[i]));
			bv = PW'($signed(in_b[i]));
			c.val = '0;
			c.sat = 1'b0;
			case (in_cmd)
				CMD_ADD:  c = clip_comp(av + bv);
				CMD_SUB:  c = clip_comp(av - bv);
				CMD_CONJ: c = (i == 0) ? clip_comp(av) : clip_comp(-av);
				default:  c.val = '0;
			endcase
			r_c[i] = c.val;
			sat_c[i] = c.sat;
			cv = (in_cmd == CMD_INV && i != 0) ? -av : av;
			neg_c[i] = cv < 0;
			mv = neg_c[i] ? -cv : cv;
			mag_c[i] = mv[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++)
					p_s1[i][j] <= $signed(in_a[i]) * $signed(in_b[j]);
				sq_s1[i] <= $signed(in_a[i]) * $signed(in_a[i]);
			end
			cmd_s1 <= in_cmd;
			r_s1 <= r_c;
			mag_s1 <= mag_c;
			neg_s1 <= neg_c;
			sat_s1 <= |sat_c;
		end
	end

	// Hamilton product sums, rounded half up, and sum of squares
	always_comb begin
		logic signed [PW-1:0] ps [4];
		clip_t                c [4];
		ps[0] = PW'(p_s1[0][0]) - PW'(p_s1[1][1]) - PW'(p_s1[2][2]) - PW'(p_s1[3][3]);
		ps[1] = PW'(p_s1[0][1]) + PW'(p_s1[1][0]) + PW'(p_s1[2][3]) - PW'(p_s1[3][2]);
		ps[2] = PW'(p_s1[0][2]) + PW'(p_s1[2][0]) + PW'(p_s1[3][1]) - PW'(p_s1[1][3]);
		ps[3] = PW'(p_s1[0][3]) + PW'(p_s1[3][0]) + PW'(p_s1[1][2]) - PW'(p_s1[2][1]);
		for (int i = 0; i < 4; i++)
			c[i] = clip_comp((ps[i] + RND_HALF) >>> FB);
		nx2.cmd = cmd_s1;
		nx2.mag = mag_s1;
		nx2.neg = neg_s1;
		if (cmd_s1 == CMD_MUL) begin
			for (int i = 0; i < 4; i++) nx2.r[i] = c[i].val;
			nx2.sat = c[0].sat | c[1].sat | c[2].sat | c[3].sat;
		end else begin
			nx2.r = r_s1;
			nx2.sat = sat_s1;
		end
		nx2.s = SW'(sq_s1[0]) + SW'(sq_s1[1]) + SW'(sq_s1[2]) + SW'(sq_s1[3]);
		nx2.rem = nx2.s;
		nx2.res = '0;
		nx2.sbit = SW'(1) << (SW - 1);
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) d_s2 <= nx2;
	end

endmodule

@@ hdl/qau_sqrt_cell.sv @@
// Square-root cell: settles one bit of the integer root per stage.
`timescale 1ns / 1ps
module qau_sqrt_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  qau_pkg::sq_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output qau_pkg::sq_t  out_data
);
	import qau_pkg::*;

	logic v_q;
	sq_t  d_q, nx;

	assign in_ready = !v_q || out_ready;
	assign out_valid = v_q;
	assign out_data = d_q;

	always_comb begin
		logic [SW+1:0] t;
		logic          ge;
		nx = in_data;
		t = (SW+2)'(in_data.res) + (SW+2)'(in_data.sbit);
		ge = (SW+2)'(in_data.rem) >= t;
		if (ge) begin
			nx.rem = in_data.rem - t[SW-1:0];
			nx.res = (in_data.res >> 1) + (SW+1)'(in_data.sbit);
		end else begin
			nx.res = in_data.res >> 1;
		end
		nx.sbit = in_data.sbit >> 2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else if (in_ready) v_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) d_q <= nx;
	end

endmodule

@@ hdl/qau_div_cell.sv @@
// Divider cell: one restoring quotient bit for each of the four lanes.
`timescale 1ns / 1ps
module qau_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  qau_pkg::dv_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output qau_pkg::dv_t  out_data
);
	import qau_pkg::*;

	logic v_q;
	dv_t  d_q, nx;

	assign in_ready = !v_q || out_ready;
	assign out_valid = v_q;
	assign out_data = d_q;

	always_comb begin
		logic ge;
		nx = in_data;
		for (int i = 0; i < 4; i++) begin
			ge = in_data.rem[i] >= in_data.dsh;
			if (ge) nx.rem[i] = in_data.rem[i] - in_data.dsh;
			nx.q[i] = {in_data.q[i][QB-2:0], ge};
		end
		nx.dsh = in_data.dsh >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else if (in_ready) v_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) d_q <= nx;
	end

endmodule

@@ hdl/quaternion_arithmetic_unit.sv @@
// Top level of the quaternion unit: front end, root chain, set-up stage, divider chain, output stage.
`timescale 1ns / 1ps
// Quaternion arithmetic unit, signed Q4.12 components.
// operands: request channel (valid/ready) with command and quaternions a, b.
//   Commands: add, subtract, Hamilton product, conjugate of a, inverse of a,
//   normalise a, norm of a. Code 7 returns all zeros.
// results: one result per request, in request order: r_w..r_z, norm_value,
//   divide_by_zero and saturated.
// Every request runs the full pipe, whatever its command: 2 front stages
//   (multipliers, then sums), 17 root cells, 1 set-up stage, 18 divider
//   cells and the output register; the stages hold 39 requests in flight.
// Throughput is one request per cycle while results.ready is high.
// Each stage loads whenever it is empty or its successor moves, so bubbles
//   close up and new requests are taken while a finished result waits.
//   Once every stage is full and results.ready is low, operands.ready drops.
// Reset clears the stage valid bits only; no output is offered until the
//   first request has passed through.
// Inverse and normalise with a zero norm give zero components and raise
//   divide_by_zero; clipped components raise saturated.
`include "quaternion_arithmetic_unit_defines.svh"
module quaternion_arithmetic_unit (
	input  logic       clk,
	input  logic       arst_n,
	qau_op_if.sink     operands,
	qau_res_if.source  results
);
	import qau_pkg::*;

	logic [SQ_CELLS:0]    sq_v, sq_rdy;
	sq_t                  sq_d [SQ_CELLS+1];
	logic [DV_CELLS:0]    dv_v, dv_rdy;
	dv_t                  dv_d [DV_CELLS+1];
	dv_t                  prep_q, prep_nx;
	logic                 prep_v_q, fin_rdy;

	logic                 out_v_q;
	logic [3:0][CW-1:0]   r_q, r_nx;
	logic [NW-1:0]        norm_q, norm_nx;
	logic                 dz_q, dz_nx, sat_q, sat_nx;

	// front end
	qau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operands.valid),
		.in_ready  (operands.ready),
		.in_cmd    (operands.command),
		.in_a      ({operands.a_z, operands.a_y, operands.a_x, operands.a_w}),
		.in_b      ({operands.b_z, operands.b_y, operands.b_x, operands.b_w}),
		.out_valid (sq_v[0]),
		.out_ready (sq_rdy[0]),
		.out_data  (sq_d[0])
	);

	// root chain
	for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
		qau_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (sq_v[k]),
			.in_ready  (sq_rdy[k]),
			.in_data   (sq_d[k]),
			.out_valid (sq_v[k+1]),
			.out_ready (sq_rdy[k+1]),
			.out_data  (sq_d[k+1])
		);
	end

	// set-up stage: final root rounding, divisor and numerators
	assign sq_rdy[SQ_CELLS] = !prep_v_q || dv_rdy[0];

	always_comb begin
		sq_t            sv;
		logic [NW-1:0]  nrm;
		logic [SW-1:0]  dvs;
		logic           is_div, is_inv;
		sv = sq_d[SQ_CELLS];
		nrm = NW'(sv.res + (SW+1)'((SW+1)'(sv.rem) > sv.res));
		is_inv = sv.cmd == CMD_INV;
		is_div = is_inv || sv.cmd == CMD_NRMZ;
		dvs = is_inv ? sv.s : SW'(nrm);
		prep_nx.cmd = sv.cmd;
		prep_nx.r = sv.r;
		prep_nx.sat = sv.sat;
		prep_nx.dz = is_div && sv.s == '0;
		prep_nx.norm = (sv.cmd == CMD_NRMZ || sv.cmd == CMD_NORM) ? nrm : '0;
		prep_nx.dsh = DW'(dvs) << (CW + 1);
		for (int i = 0; i < 4; i++) begin
			prep_nx.rem[i] = is_inv ? (DW'(sv.mag[i]) << (2 * FB + 1))
				: (DW'(sv.mag[i]) << (FB + 1));
			prep_nx.q[i] = '0;
		end
		prep_nx.neg = sv.neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) prep_v_q <= 1'b0;
		else if (sq_rdy[SQ_CELLS]) prep_v_q <= sq_v[SQ_CELLS];
	end

	always_ff @(posedge clk) begin
		if (sq_rdy[SQ_CELLS] && sq_v[SQ_CELLS]) prep_q <= prep_nx;
	end

	assign dv_v[0] = prep_v_q;
	assign dv_d[0] = prep_q;

	// divider chain
	for (genvar k = 0; k < DV_CELLS; k++) begin : g_div
		qau_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv_v[k]),
			.in_ready  (dv_rdy[k]),
			.in_data   (dv_d[k]),
			.out_valid (dv_v[k+1]),
			.out_ready (dv_rdy[k+1]),
			.out_data  (dv_d[k+1])
		);
	end

	// output stage: quotient rounding, clipping and result selection
	assign fin_rdy = !out_v_q || results.ready;
	assign dv_rdy[DV_CELLS] = fin_rdy;

	always_comb begin
		dv_t                dd;
		logic [QB-1:0]      qr, cap;
		logic [3:0]         ovf;
		logic [3:0][CW-1:0] qv;
		dd = dv_d[DV_CELLS];
		for (int i = 0; i < 4; i++) begin
			qr = (QB'(dd.q[i][QB-2:0]) + QB'(1)) >> 1;
			cap = dd.neg[i] ? (QB'(1) << (CW - 1)) : ((QB'(1) << (CW - 1)) - QB'(1));
			ovf[i] = dd.q[i][QB-1] || qr > cap;
			if (ovf[i]) qv[i] = dd.neg[i] ? CMIN : CMAX;
			else qv[i] = dd.neg[i] ? -qr[CW-1:0] : qr[CW-1:0];
		end
		r_nx = '0;
		norm_nx = '0;
		dz_nx = 1'b0;
		sat_nx = 1'b0;
		unique case (dd.cmd) inside
			CMD_ADD, CMD_SUB, CMD_MUL, CMD_CONJ: begin
				r_nx = dd.r;
				sat_nx = dd.sat;
			end
			CMD_INV, CMD_NRMZ: begin
				norm_nx = dd.norm;
				if (dd.dz) begin
					dz_nx = 1'b1;
				end else begin
					r_nx = qv;
					sat_nx = |ovf;
				end
			end
			CMD_NORM: norm_nx = dd.norm;
			default: r_nx = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (fin_rdy) out_v_q <= dv_v[DV_CELLS];
	end

	always_ff @(posedge clk) begin
		if (fin_rdy && dv_v[DV_CELLS]) begin
			r_q <= r_nx;
			norm_q <= norm_nx;
			dz_q <= dz_nx;
			sat_q <= sat_nx;
		end
	end

	assign results.valid = out_v_q;
	assign results.r_w = r_q[0];
	assign results.r_x = r_q[1];
	assign results.r_y = r_q[2];
	assign results.r_z = r_q[3];
	assign results.norm_value = norm_q;
	assign results.divide_by_zero = dz_q;
	assign results.saturated = sat_q;

	// a zero norm never leaves components or a clip flag behind
	`QAU_ASSERT_IMP(a_dz_zero, clk, arst_n, results.valid && results.divide_by_zero,
		r_q == '0 && !results.saturated)
	// the rounded root of a sum of four squares never exceeds NORM_MAX (2^16)
	`QAU_ASSERT_IMP(a_norm_range, clk, arst_n, results.valid,
		results.norm_value <= NORM_MAX)
	// requests are refused only once every stage holds an item
	`QAU_ASSERT_IMP(a_full_stall, clk, arst_n, !operands.ready,
		(&sq_v[SQ_CELLS:1]) && (&dv_v) && out_v_q)
	// last divider cell keeps its item while the output stage is stalled
	`QAU_ASSERT_NXT(a_div_hold, clk, arst_n, dv_v[DV_CELLS] && !fin_rdy,
		dv_v[DV_CELLS])

endmodule
